>>> hw/rtl/imufd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufd_pkg
// Shared types and constants for the IMU frame deframer: header and id codes,
// frame kind codes, payload store geometry and the decode result.
// ----------------------------------------------------------------------------
package imufd_pkg;

    // header and id bytes
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] ID_ATT    = 8'h01;
    localparam logic [7:0] ID_QUAT   = 8'h02;
    localparam logic [7:0] ID_MOTION = 8'h03;

    // default for the longest accepted payload
    localparam int MAX_PAYLOAD_DEF = 28;

    // payload bytes kept for decoding
    localparam int STORE_DEPTH = 12;
    localparam int STORE_IDX_W = 4;
    localparam int NUM_VALUES  = 6;

    // payload bytes each kind needs
    localparam int NEED_ATT    = 6;
    localparam int NEED_QUAT   = 8;
    localparam int NEED_MOTION = 12;

    // frame kind codes
    localparam logic [2:0] KIND_ATT       = 3'd0;
    localparam logic [2:0] KIND_QUAT      = 3'd1;
    localparam logic [2:0] KIND_MOTION    = 3'd2;
    localparam logic [2:0] KIND_OTHER     = 3'd3;
    localparam logic [2:0] KIND_CSUM_ERR  = 3'd4;

    typedef logic [STORE_DEPTH-1:0][7:0] payload_t;

    // decoded frame
    typedef struct packed {
        logic [2:0]                  kind;
        logic [NUM_VALUES-1:0][15:0] values;
    } decode_t;

endpackage

>>> hw/rtl/imufd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufd_decode
// Turns the held id, length and stored payload of a finished frame into a
// frame kind and up to six little-endian signed 16-bit values.
// ----------------------------------------------------------------------------
module imufd_decode
    import imufd_pkg::*;
#(
    parameter int LEN_W = 5
) (
    input  logic [7:0]       frame_id,
    input  logic [LEN_W-1:0] frame_len,
    input  payload_t         payload,
    output decode_t          result
);

    logic [2:0] needed;

    // pick kind by id, short frames fall back to other
    always_comb begin
        result.kind = KIND_OTHER;
        needed      = 3'd0;
        if (frame_id == ID_ATT && frame_len >= LEN_W'(NEED_ATT)) begin
            result.kind = KIND_ATT;
            needed      = 3'd3;
        end else if (frame_id == ID_QUAT && frame_len >= LEN_W'(NEED_QUAT)) begin
            result.kind = KIND_QUAT;
            needed      = 3'd4;
        end else if (frame_id == ID_MOTION && frame_len >= LEN_W'(NEED_MOTION)) begin
            result.kind = KIND_MOTION;
            needed      = 3'd6;
        end
    end

    // little-endian words, zero where the kind does not use them
    always_comb begin
        for (int i = 0; i < NUM_VALUES; i++) begin
            if (3'(i) < needed) begin
                result.values[i] = {payload[2*i+1], payload[2*i]};
            end else begin
                result.values[i] = 16'h0000;
            end
        end
    end

endmodule

>>> hw/rtl/imu_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_deframer_core
// Byte-serial deframer for an IMU serial link with additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per beat, one beat per clock when the result side
// keeps up. The parser hunts for 0x55 0x55, reads id, length (lengths above
// MAX_PAYLOAD drop the frame) and payload, and on the checksum byte loads
// one result beat into the output register; it shows on m_ after the next
// clock edge. s_ready is low only while that output register holds a beat
// that m_ready has not taken, so the only stall comes from the result side.
// The two frame counters update with each result and are shown with it.
// ----------------------------------------------------------------------------
module imu_frame_deframer_core
    import imufd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_frame_kind,
    output logic [7:0]         m_frame_id,
    output logic signed [15:0] m_value0,
    output logic signed [15:0] m_value1,
    output logic signed [15:0] m_value2,
    output logic signed [15:0] m_value3,
    output logic signed [15:0] m_value4,
    output logic signed [15:0] m_value5,
    output logic [31:0]        m_good_frame_count,
    output logic [31:0]        m_checksum_error_count
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  id_reg, id_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [LEN_W-1:0]            index_reg, index_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [31:0]                 good_reg, good_next;
    logic [31:0]                 bad_reg, bad_next;
    logic                        m_valid_reg, m_valid_next;
    logic [2:0]                  kind_reg;
    logic [7:0]                  fid_reg;
    logic [NUM_VALUES-1:0][15:0] values_reg;
    payload_t                    store_reg;

    logic       beat;
    logic       emit;
    logic       csum_ok;
    logic [7:0] sum_add;
    decode_t    dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign beat    = s_valid && s_ready;
    assign sum_add = sum_reg + s_rx_byte;
    assign emit    = beat && (phase_reg == PH_SUM);
    assign csum_ok = (sum_reg == s_rx_byte);

    imufd_decode #(
        .LEN_W (LEN_W)
    ) u_decode (
        .frame_id  (id_reg),
        .frame_len (len_reg),
        .payload   (store_reg),
        .result    (dec)
    );

    // parser next state
    always_comb begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        index_next   = index_reg;
        sum_next     = sum_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (beat) begin
            case (phase_reg)
                PH_HDR1: begin
                    if (s_rx_byte == HDR_BYTE) begin
                        sum_next   = s_rx_byte;
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    if (s_rx_byte == HDR_BYTE) begin
                        sum_next   = sum_add;
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_ID: begin
                    id_next    = s_rx_byte;
                    sum_next   = sum_add;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (s_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        len_next   = LEN_W'(s_rx_byte);
                        index_next = '0;
                        sum_next   = sum_add;
                        phase_next = (s_rx_byte == 8'h00) ? PH_SUM : PH_DATA;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_DATA: begin
                    index_next = index_reg + LEN_W'(1);
                    sum_next   = sum_add;
                    if (index_next >= len_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    phase_next   = PH_HDR1;
                    m_valid_next = 1'b1;
                    if (csum_ok) begin
                        good_next = good_reg + 32'd1;
                    end else begin
                        bad_next = bad_reg + 32'd1;
                    end
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR1;
            id_reg      <= '0;
            len_reg     <= '0;
            index_reg   <= '0;
            sum_reg     <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            index_reg   <= index_next;
            sum_reg     <= sum_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload store, bytes past the store are only summed
    always_ff @(posedge aclk) begin
        if (beat && phase_reg == PH_DATA && index_reg < LEN_W'(STORE_DEPTH)) begin
            store_reg[index_reg[STORE_IDX_W-1:0]] <= s_rx_byte;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (emit) begin
            fid_reg <= id_reg;
            if (csum_ok) begin
                kind_reg   <= dec.kind;
                values_reg <= dec.values;
            end else begin
                kind_reg   <= KIND_CSUM_ERR;
                values_reg <= '0;
            end
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_frame_kind           = kind_reg;
    assign m_frame_id             = fid_reg;
    assign m_value0               = values_reg[0];
    assign m_value1               = values_reg[1];
    assign m_value2               = values_reg[2];
    assign m_value3               = values_reg[3];
    assign m_value4               = values_reg[4];
    assign m_value5               = values_reg[5];
    assign m_good_frame_count     = good_reg;
    assign m_checksum_error_count = bad_reg;

endmodule
